/* rtl/tsls_pkg.sv */
package tsls_pkg;

   localparam int POINTS = 64;
   localparam int IDX_W  = $clog2(POINTS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int LIM_W  = IDX_W + 2;

   localparam int VOLT_W  = 16;
   localparam int CURR_W  = 16;
   localparam int DWELL_W = 24;
   localparam int LOOP_W  = 16;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_START_POINT = 2'd0;
   localparam logic [1:0] REG_POINT_COUNT = 2'd1;
   localparam logic [1:0] REG_CYCLE_LIMIT = 2'd2;

   // Input item actions.
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic [DWELL_W-1:0] HOLD_MAX = {DWELL_W{1'b1}};
   localparam logic [LOOP_W-1:0]  LOOP_MAX = {LOOP_W{1'b1}};

   typedef struct packed {
      logic               action;
      logic               enable;
      logic               running;
      logic               power_on;
      logic [IDX_W-1:0]   point_index;
      logic [VOLT_W-1:0]  point_voltage;
      logic [CURR_W-1:0]  point_current;
      logic [DWELL_W-1:0] point_dwell;
   } req_type;

   typedef struct packed {
      logic              setpoint_valid;
      logic [VOLT_W-1:0] voltage;
      logic [CURR_W-1:0] current;
      logic              loop_changed;
      logic [LOOP_W-1:0] loop_count;
      logic              finished;
      logic [IDX_W-1:0]  position;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  start_point;
      logic [CNT_W-1:0]  point_count;
      logic [LOOP_W-1:0] cycle_limit;
   } cfg_type;

   typedef struct packed {
      logic [VOLT_W-1:0]  voltage;
      logic [CURR_W-1:0]  current;
      logic [DWELL_W-1:0] dwell;
   } entry_type;

   localparam cfg_type CFG_RESET = '{
      start_point: '0,
      point_count: CNT_W'(POINTS),
      cycle_limit: '0
   };

   // True when the entry after idx falls outside the window or the table.
   function automatic logic window_wrap(logic [IDX_W-1:0] idx, cfg_type cfg);
      logic [CNT_W-1:0] nxt;
      logic [LIM_W-1:0] lim;
      nxt = {1'b0, idx} + CNT_W'(1);
      lim = {2'b00, cfg.start_point} + {1'b0, cfg.point_count};
      return (nxt >= CNT_W'(POINTS)) || ({1'b0, nxt} >= lim);
   endfunction

   function automatic logic [IDX_W-1:0] next_index(logic [IDX_W-1:0] idx, cfg_type cfg);
      return window_wrap(idx, cfg) ? cfg.start_point : idx + IDX_W'(1);
   endfunction

endpackage

/* rtl/tsls_csr.sv */
module tsls_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsls_pkg::CSR_AW-1:0] paddr,
   input  logic [tsls_pkg::CSR_DW-1:0] pwdata,
   output logic [tsls_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output tsls_pkg::cfg_type           cfg,
   output tsls_pkg::cfg_type           cfg_next
);
   import tsls_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_START_POINT: cfg_in.start_point = pwdata[IDX_W-1:0];
            REG_POINT_COUNT: cfg_in.point_count = pwdata[CNT_W-1:0];
            REG_CYCLE_LIMIT: cfg_in.cycle_limit = pwdata[LOOP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_START_POINT: prdata = CSR_DW'(cfg_ff.start_point);
         REG_POINT_COUNT: prdata = CSR_DW'(cfg_ff.point_count);
         REG_CYCLE_LIMIT: prdata = CSR_DW'(cfg_ff.cycle_limit);
         default:         prdata = '0;
      endcase
   end

   assign cfg      = cfg_ff;
   assign cfg_next = reset ? CFG_RESET : cfg_in;

endmodule

/* rtl/tsls_table.sv */
module tsls_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tsls_pkg::IDX_W-1:0] wr_addr,
   input  tsls_pkg::entry_type        wr_data,
   input  logic [tsls_pkg::IDX_W-1:0] rd_a_addr,
   input  logic [tsls_pkg::IDX_W-1:0] rd_b_addr,
   output tsls_pkg::entry_type        rd_a_data,
   output tsls_pkg::entry_type        rd_b_data
);
   import tsls_pkg::*;

   entry_type mem [POINTS];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // Reads that hit the entry being written return the new data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && wr_addr == rd_a_addr) ? wr_data : mem[rd_a_addr];
      rd_b_ff <= (wr_en && wr_addr == rd_b_addr) ? wr_data : mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* rtl/timed_setpoint_list_sequencer.sv */
// A result strobes on rsp_strobe in the cycle after its transaction is taken.
// The block takes one transaction per cycle; busy stays low, the receiver cannot stall.
// The table is read ahead at the next-state position, so each step is
// one table lookup, one dwell compare and one saturating add.
// Reset (synchronous, active high) clears position, hold and loop counts and loads
// the register defaults; table contents are undefined until written.
module timed_setpoint_list_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tsls_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output tsls_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsls_pkg::CSR_AW-1:0] paddr,
   input  logic [tsls_pkg::CSR_DW-1:0] pwdata,
   output logic [tsls_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import tsls_pkg::*;

   cfg_type cfg;
   cfg_type cfg_next;

   logic [IDX_W-1:0]   active_ff,  active_in;
   logic [DWELL_W-1:0] hold_ff,    hold_in;
   logic [LOOP_W-1:0]  passes_ff,  passes_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff,     rsp_in;

   logic               accept;
   logic               tbl_wr_en;
   entry_type          tbl_wr_data;
   entry_type          cur_entry;
   entry_type          nxt_entry;
   logic [IDX_W-1:0]   rd_a_addr;
   logic [IDX_W-1:0]   rd_b_addr;

   tsls_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .cfg_next (cfg_next)
   );

   // The block never holds off a transaction.
   assign busy   = 1'b0;
   assign accept = start;

   // A write transaction stores one table entry.
   assign tbl_wr_en           = accept && req_data.action == ACT_WRITE;
   assign tbl_wr_data.voltage = req_data.point_voltage;
   assign tbl_wr_data.current = req_data.point_current;
   assign tbl_wr_data.dwell   = req_data.point_dwell;

   // Port A follows the position the next transaction will see, port B the entry
   // that follows it in the window. Both are addressed from next-state values so
   // the registered read data lines up with the state registers.
   assign rd_a_addr = reset ? '0 : active_in;
   assign rd_b_addr = next_index(rd_a_addr, cfg_next);

   tsls_table u_table (
      .clock     (clock),
      .wr_en     (tbl_wr_en),
      .wr_addr   (req_data.point_index),
      .wr_data   (tbl_wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (cur_entry),
      .rd_b_data (nxt_entry)
   );

   // Sequencing step for one tick transaction.
   always_comb begin
      logic stop;
      logic [DWELL_W-1:0] hold_tmp;
      stop      = 1'b0;
      hold_tmp  = hold_ff;
      active_in = active_ff;
      hold_in   = hold_ff;
      passes_in = passes_ff;
      rsp_in    = '0;

      if (accept && req_data.action == ACT_TICK) begin
         if (!req_data.enable) begin
            // Disabled list mode rewinds to the start of the window.
            hold_in   = '0;
            active_in = cfg.start_point;
            passes_in = '0;
         end else if (req_data.running && req_data.power_on) begin
            // On the first pass the start entry is applied as the tick begins.
            if (passes_ff == '0 && active_ff == cfg.start_point) begin
               rsp_in.setpoint_valid = 1'b1;
               rsp_in.voltage        = cur_entry.voltage;
               rsp_in.current        = cur_entry.current;
            end
            // Dwell met: move on, wrapping at the end of the window or table.
            if (hold_ff >= cur_entry.dwell) begin
               hold_tmp  = '0;
               active_in = next_index(active_ff, cfg);
               if (window_wrap(active_ff, cfg)) begin
                  if (passes_ff != LOOP_MAX) begin
                     passes_in = passes_ff + LOOP_W'(1);
                  end
                  rsp_in.loop_changed = 1'b1;
                  if (cfg.cycle_limit != '0 && passes_in >= cfg.cycle_limit) begin
                     rsp_in.finished = 1'b1;
                     stop            = 1'b1;
                  end
               end
               if (!stop) begin
                  rsp_in.setpoint_valid = 1'b1;
                  rsp_in.voltage        = nxt_entry.voltage;
                  rsp_in.current        = nxt_entry.current;
               end
            end
            // The hold counter advances on every running, powered-on tick that does not finish.
            hold_in = hold_tmp;
            if (!stop && hold_tmp != HOLD_MAX) begin
               hold_in = hold_tmp + DWELL_W'(1);
            end
         end
      end

      rsp_in.loop_count = passes_in;
      rsp_in.position   = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         hold_ff       <= '0;
         passes_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         hold_ff       <= hold_in;
         passes_ff     <= passes_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Result payload register, loaded with each transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every taken transaction yields exactly one result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe_ff)
      else $error("transaction without a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_strobe_ff)
      else $error("result without a transaction");

   // A finish only comes with a completed pass, and with no new setpoint or a rewind to the window start.
   a_finish_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.finished |->
         rsp_ff.loop_changed && !rsp_ff.setpoint_valid || rsp_ff.loop_changed
         && rsp_ff.position == cfg.start_point)
      else $error("finish without a completed pass");

   // A disabled tick clears the hold and loop counts.
   a_disable_clears: assert property (@(posedge clock) disable iff (reset)
      start && req_data.action == ACT_TICK && !req_data.enable |=>
         hold_ff == '0 && passes_ff == '0)
      else $error("disabled tick left counts set");

endmodule
